>>> rtl/mme_pkg.sv
package mme_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 16;

	// Fixed field widths
	localparam int DIM_W      = 4;
	localparam int IDX_W      = 3;
	localparam int VAL_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} reg_index_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic signed [VAL_W-1:0]  out_value;
		logic                     saturated;
		logic                     last;
	} result_t;

endpackage

>>> rtl/mme_ram.sv
module mme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/matrix_multiply_engine_unit.sv
// Dense matrix multiply, C = A x B, in signed Q16.16 (FRAC_BITS fractional bits).
// A write transaction (opcode write A / write B) stores one element and busy
// stays low, so writes may be issued back to back. A compute transaction raises
// busy and walks C in row-major order, one multiply-accumulate per cycle
// through the one shared 32x32 multiplier fed by the single read port of each
// store. Each dimension is first clipped to MAX_DIM; a compute with no rows or
// no columns yields nothing and leaves busy low. The last result strobes in the
// first cycle with busy low. Results appear on result for exactly one cycle
// each, marked by strobe; the receiver cannot stall them, so it must take
// every strobe. Elements read during a compute must have been written before;
// writes outside MAX_DIM are dropped and dimensions above MAX_DIM act as MAX_DIM.
module matrix_multiply_engine_unit #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            start,
	output logic                            busy,
	input  mme_pkg::cmd_t                   cmd,
	// result channel
	output logic                            strobe,
	output mme_pkg::result_t                result,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mme_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	// full-precision sum of up to MAX_DIM 64-bit products, plus headroom
	localparam int ACC_W = 65 + IW;

	typedef struct packed {
		logic          first;
		logic          last_k;
		logic          zero;
		logic          last_el;
		logic [IW-1:0] i;
		logic [IW-1:0] j;
	} tag_t;

	// configuration registers
	logic [DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [DIM_W-1:0] m_eff, p_eff, n_eff;

	// sequencer
	logic          run_q;
	logic [IW-1:0] i_q, j_q, k_q;
	tag_t          tag_c;
	logic          last_j, last_i;

	// pipeline
	logic                   v_s1, v_s2, v_s3;
	tag_t                   tag_s1, tag_s2, tag_s3;
	logic signed [63:0]     prod_s2;
	logic signed [ACC_W-1:0] acc_q, acc_next;

	// result formatting
	logic signed [ACC_W-1:0] shifted;
	logic [ACC_W-32:0]       upper;
	logic                    fits;

	// store ports
	logic             accept;
	logic             in_range;
	logic             we_a, we_b;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr_a, raddr_b;
	logic [VAL_W-1:0] rd_a, rd_b;

	// Configuration: a value above MAX_DIM acts as MAX_DIM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(1);
			inner_q <= DIM_W'(1);
			cols_q  <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_q  <= cfg_data;
				REG_INNER_DIM: inner_q <= cfg_data;
				REG_COLS_B:    cols_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign m_eff = (int'(rows_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : rows_q;
	assign p_eff = (int'(inner_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : inner_q;
	assign n_eff = (int'(cols_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : cols_q;

	// Command acceptance and element writes
	assign accept   = start && !busy;
	assign in_range = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);
	assign we_a     = accept && in_range && (cmd.opcode == OP_WRITE_A);
	assign we_b     = accept && in_range && (cmd.opcode == OP_WRITE_B);
	assign waddr    = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));

	// Read addresses follow the sequencer: A[i][k] and B[k][j]
	assign raddr_a = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign raddr_b = AW'(int'(k_q) * MAX_DIM + int'(j_q));

	mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (cmd.value),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (cmd.value),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	// Tag for the step issued this cycle. An empty inner dimension still
	// issues one step per element, with the product forced to zero.
	always_comb begin
		tag_c.first   = (k_q == '0);
		tag_c.zero    = (p_eff == '0);
		tag_c.last_k  = tag_c.zero || ((DIM_W'(k_q) + DIM_W'(1)) == p_eff);
		tag_c.i       = i_q;
		tag_c.j       = j_q;
		last_j        = (DIM_W'(j_q) + DIM_W'(1)) == n_eff;
		last_i        = (DIM_W'(i_q) + DIM_W'(1)) == m_eff;
		tag_c.last_el = tag_c.last_k && last_j && last_i;
	end

	// Sequencer: advance k, then j, then i; drop run after the final step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
		end else if (run_q) begin
			if (!tag_c.last_k) begin
				k_q <= k_q + IW'(1);
			end else begin
				k_q <= '0;
				if (!last_j) begin
					j_q <= j_q + IW'(1);
				end else begin
					j_q <= '0;
					if (!last_i) begin
						i_q <= i_q + IW'(1);
					end else begin
						i_q   <= '0;
						run_q <= 1'b0;
					end
				end
			end
		end else if (accept && (cmd.opcode == OP_COMPUTE) &&
				(m_eff != '0) && (n_eff != '0)) begin
			run_q <= 1'b1;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= run_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && tag_s2.last_k;
		end
	end

	assign busy = run_q || v_s1 || v_s2 || v_s3;

	// s1: store data arrives; s2: product; then accumulate
	assign acc_next = (tag_s2.first ? '0 : acc_q) +
		{{(ACC_W-64){prod_s2[63]}}, prod_s2};

	always_ff @(posedge clk) begin
		tag_s1 <= tag_c;
		tag_s2 <= tag_s1;
		if (tag_s1.zero) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= $signed(rd_a) * $signed(rd_b);
		end
		if (v_s2) begin
			acc_q  <= acc_next;
			tag_s3 <= tag_s2;
		end
	end

	// Truncate toward minus infinity, then clip to 32 bits
	assign shifted = acc_q >>> FRAC_BITS;
	assign upper   = shifted[ACC_W-1:31];
	assign fits    = (&upper) || !(|upper);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			result.out_row   <= IDX_W'(tag_s3.i);
			result.out_col   <= IDX_W'(tag_s3.j);
			result.saturated <= !fits;
			result.last      <= tag_s3.last_el;
			if (fits) begin
				result.out_value <= shifted[31:0];
			end else if (acc_q[ACC_W-1]) begin
				result.out_value <= 32'sh8000_0000;
			end else begin
				result.out_value <= 32'sh7FFF_FFFF;
			end
		end
	end

	// The final result leaves only once everything behind it has drained
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("last result shown while work is still in flight");

	// More results follow a non-final one, so the block must still be busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final result with no work in flight");

	// A compute with a non-empty result must occupy the block
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.opcode == OP_COMPUTE) && (m_eff != '0) && (n_eff != '0)
		|=> busy)
		else $error("compute taken but block not busy");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mme_pkg::*;

	localparam int MAX_DIM   = MAX_DIM_DEF;
	localparam int FRAC_BITS = FRAC_BITS_DEF;

	// Codes that the package leaves without a name: the spare opcode and the
	// spare register index, both of which the block must ignore.
	localparam logic [1:0]           OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Cycles to let pass once nothing is due, so that a compute transaction
	// that yields no element (or a stray strobe) has time to show itself.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 16;
	// Longest legal stretch without any accepted transaction is an 8x8x8
	// compute before its first element. Allow far more.
	localparam int WATCHDOG      = 2000;

	localparam logic signed [67:0] Q_MAX = 68'sd2147483647;
	localparam logic signed [67:0] Q_MIN = -68'sd2147483648;

	// One row of the directed plan: either a dimension change or a command,
	// optionally with the single 1x1 result typed in by hand.
	typedef struct {
		bit               is_dims;
		logic [3:0]       rows, inner, cols;
		cmd_t             op;
		bit               typed;
		result_t          elem;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	cmd_t                  cmd       = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  strobe;
	result_t               result;

	// Shadow of the block: both stores, which entries hold data, and the
	// three dimension registers.
	logic signed [31:0] a_shadow [MAX_DIM][MAX_DIM];
	logic signed [31:0] b_shadow [MAX_DIM][MAX_DIM];
	bit                 a_loaded [MAX_DIM][MAX_DIM];
	bit                 b_loaded [MAX_DIM][MAX_DIM];
	logic [3:0]         dim_rows  = 4'd1;
	logic [3:0]         dim_inner = 4'd1;
	logic [3:0]         dim_cols  = 4'd1;

	result_t c_elems_due [$];
	result_t c_want;
	int      n_errors = 0;
	int      n_cmds_done = 0;
	int      quiet_cycles = 0;

	matrix_multiply_engine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.strobe   (strobe),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset once, and never again.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %-10s got %08h want %08h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic int clamp_dim(input logic [3:0] d);
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// Dot product of row i of A with column j of B, summed exactly, then
	// truncated towards minus infinity and clipped to Q16.16.
	function automatic logic [31:0] dot_q16(input int i, input int j, input int depth,
			output logic clipped);
		logic signed [67:0] acc;
		logic signed [67:0] shifted;
		acc = '0;
		for (int k = 0; k < depth; k++)
			acc = acc + a_shadow[i][k] * b_shadow[k][j];
		shifted = acc >>> FRAC_BITS;
		clipped = 1'b0;
		if (shifted > Q_MAX) begin
			clipped = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (shifted < Q_MIN) begin
			clipped = 1'b1;
			return 32'h8000_0000;
		end
		return shifted[31:0];
	endfunction

	// Queue every element of C, row-major, that a compute transaction yields now.
	task automatic queue_product();
		int      m, p, n;
		result_t e;
		m = clamp_dim(dim_rows);
		p = clamp_dim(dim_inner);
		n = clamp_dim(dim_cols);
		for (int i = 0; i < m; i++)
			for (int j = 0; j < n; j++) begin
				e.out_row   = 3'(i);
				e.out_col   = 3'(j);
				e.out_value = dot_q16(i, j, p, e.saturated);
				e.last      = (i == m - 1) && (j == n - 1);
				c_elems_due.push_back(e);
			end
	endtask

	// Apply one accepted transaction to the shadow.
	task automatic apply_cmd(input cmd_t c, input bit predicted);
		case (c.opcode)
			OP_WRITE_A: begin
				a_shadow[c.row][c.col] = c.value;
				a_loaded[c.row][c.col] = 1'b1;
				n_cmds_done++;
			end
			OP_WRITE_B: begin
				b_shadow[c.row][c.col] = c.value;
				b_loaded[c.row][c.col] = 1'b1;
				n_cmds_done++;
			end
			OP_COMPUTE: begin
				if (predicted)
					queue_product();
				n_cmds_done++;
			end
			default: ;
		endcase
	endtask

	function automatic cmd_t mk_cmd(input logic [1:0] code, input int r, input int c,
			input logic [31:0] v);
		cmd_t x;
		x.opcode = opcode_t'(code);
		x.row    = 3'(r);
		x.col    = 3'(c);
		x.value  = v;
		return x;
	endfunction

	// Mix of any 32-bit pattern, modest Q16.16 numbers, the two extremes and
	// small whole numbers of either sign.
	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom();
		if (r < 80)
			return $urandom_range(0, 32'h7FFFF) - 32'h40000;
		if (r < 90)
			return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
		return ($urandom_range(0, 6) - 3) << FRAC_BITS;
	endfunction

	function automatic logic [3:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return 4'd0;
			1:       return 4'($urandom_range(MAX_DIM + 1, 15));
			2:       return 4'(MAX_DIM);
			default: return 4'($urandom_range(1, 4));
		endcase
	endfunction

	// Idle cycles before the next offer: each cycle stays idle with the
	// given chance, so that share of sender cycles is idle overall.
	function automatic int pick_gap(input int idle_pct);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		return gap;
	endfunction

	// Offer one transaction and hold it until accepted. busy only moves on
	// the rising edge, so its value at the falling edge is what the next
	// rising edge sees. start stays high on return so that a following
	// transaction can go out back to back.
	task automatic issue(input cmd_t c, input int gap, input bit predicted);
		bit ready;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do begin
			@(negedge clk);
			ready = !busy;
			@(posedge clk);
		end while (!ready);
		apply_cmd(c, predicted);
	endtask

	// Drop start and hold off until every element due has arrived and the
	// block has gone quiet.
	task automatic drain();
		start <= 1'b0;
		while (c_elems_due.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three dimensions, then poke the spare index, which must be
	// ignored. Only ever called with the block idle.
	task automatic set_dims(input logic [3:0] m, input logic [3:0] p, input logic [3:0] n);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data  <= m;
		@(posedge clk);
		dim_rows   = m;
		cfg_index <= REG_INNER_DIM;
		cfg_data  <= p;
		@(posedge clk);
		dim_inner  = p;
		cfg_index <= REG_COLS_B;
		cfg_data  <= n;
		@(posedge clk);
		dim_cols   = n;
		cfg_index <= REG_UNUSED;
		cfg_data  <= 4'($urandom());
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Write every entry the next product reads that has never been written,
	// so that no compute ever reads an undefined store entry.
	task automatic fill_operands(input int idle_pct);
		int m, p, n;
		m = clamp_dim(dim_rows);
		p = clamp_dim(dim_inner);
		n = clamp_dim(dim_cols);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < p; k++)
				if (!a_loaded[i][k])
					issue(mk_cmd(OP_WRITE_A, i, k, pick_value()), pick_gap(idle_pct), 1'b1);
		for (int k = 0; k < p; k++)
			for (int j = 0; j < n; j++)
				if (!b_loaded[k][j])
					issue(mk_cmd(OP_WRITE_B, k, j, pick_value()), pick_gap(idle_pct), 1'b1);
	endtask

	function automatic plan_row_t row_cmd(input logic [1:0] code, input int r, input int c,
			input logic [31:0] v);
		plan_row_t x;
		x       = '{default: '0};
		x.op    = mk_cmd(code, r, c, v);
		return x;
	endfunction

	// Compute with a 1x1 product whose value is known by inspection.
	function automatic plan_row_t row_calc(input logic [31:0] v, input logic clipped);
		plan_row_t x;
		x                = '{default: '0};
		x.op             = mk_cmd(OP_COMPUTE, 0, 0, 32'h0);
		x.typed          = 1'b1;
		x.elem.out_value = v;
		x.elem.saturated = clipped;
		x.elem.last      = 1'b1;
		return x;
	endfunction

	function automatic plan_row_t row_dims(input logic [3:0] m, input logic [3:0] p,
			input logic [3:0] n);
		plan_row_t x;
		x         = '{default: '0};
		x.is_dims = 1'b1;
		x.rows    = m;
		x.inner   = p;
		x.cols    = n;
		return x;
	endfunction

	// Check each strobed element against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (c_elems_due.size() == 0) begin
				flag("unexpected", {26'h0, result.out_row, result.out_col}, 32'h0);
			end else begin
				c_want = c_elems_due.pop_front();
				if (result.out_row !== c_want.out_row)
					flag("out_row", result.out_row, c_want.out_row);
				if (result.out_col !== c_want.out_col)
					flag("out_col", result.out_col, c_want.out_col);
				if (result.out_value !== c_want.out_value)
					flag("out_value", result.out_value, c_want.out_value);
				if (result.saturated !== c_want.saturated)
					flag("saturated", result.saturated, c_want.saturated);
				if (result.last !== c_want.last)
					flag("last", result.last, c_want.last);
			end
		end
	end

	// Watchdog: count cycles with no command, element or register write taken.
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || strobe === 1'b1 || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		plan_row_t pr;
		int        idle_pct [4];
		int        pct;
		int        seg;
		int unsigned pick;

		idle_pct = '{0, 51, 37, 0};

		// Directed plan, starting from the reset dimensions of 1x1x1.
		// Unit times two, then the signed extremes against each other.
		plan.push_back(row_cmd(OP_WRITE_A, 0, 0, 32'h0001_0000));
		plan.push_back(row_cmd(OP_WRITE_B, 0, 0, 32'h0002_0000));
		plan.push_back(row_calc(32'h0002_0000, 1'b0));
		plan.push_back(row_cmd(OP_WRITE_A, 0, 0, 32'h7FFF_FFFF));
		plan.push_back(row_cmd(OP_WRITE_B, 0, 0, 32'h7FFF_FFFF));
		plan.push_back(row_calc(32'h7FFF_FFFF, 1'b1));
		plan.push_back(row_cmd(OP_WRITE_B, 0, 0, 32'h8000_0000));
		plan.push_back(row_calc(32'h8000_0000, 1'b1));
		plan.push_back(row_cmd(OP_WRITE_A, 0, 0, 32'h8000_0000));
		plan.push_back(row_calc(32'h7FFF_FFFF, 1'b1));
		// Smallest negative times most negative: exact, no clipping.
		plan.push_back(row_cmd(OP_WRITE_A, 0, 0, 32'hFFFF_FFFF));
		plan.push_back(row_calc(32'h0000_8000, 1'b0));
		// Minus one ulp squared down: truncation goes towards minus infinity.
		plan.push_back(row_cmd(OP_WRITE_B, 0, 0, 32'h0000_0001));
		plan.push_back(row_calc(32'hFFFF_FFFF, 1'b0));
		// -1.5 times 2.0.
		plan.push_back(row_cmd(OP_WRITE_A, 0, 0, 32'hFFFE_8000));
		plan.push_back(row_cmd(OP_WRITE_B, 0, 0, 32'h0002_0000));
		plan.push_back(row_calc(32'hFFFD_0000, 1'b0));
		// Spare opcode must neither write nor emit anything.
		plan.push_back(row_cmd(OP_UNUSED, 0, 0, 32'h0000_0000));
		plan.push_back(row_calc(32'hFFFD_0000, 1'b0));
		plan.push_back(row_cmd(OP_WRITE_A, 7, 7, 32'h8000_0000));
		plan.push_back(row_cmd(OP_WRITE_B, 7, 7, 32'h7FFF_FFFF));
		// Zero dimensions: no rows, empty inner sum, no columns.
		plan.push_back(row_dims(4'd0, 4'd1, 4'd1));
		plan.push_back(row_cmd(OP_COMPUTE, 0, 0, 32'h0));
		plan.push_back(row_dims(4'd1, 4'd0, 4'd1));
		plan.push_back(row_calc(32'h0000_0000, 1'b0));
		plan.push_back(row_dims(4'd1, 4'd1, 4'd0));
		plan.push_back(row_cmd(OP_COMPUTE, 0, 0, 32'h0));

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (plan[idx]) begin
			pr = plan[idx];
			if (pr.is_dims) begin
				drain();
				set_dims(pr.rows, pr.inner, pr.cols);
			end else begin
				issue(pr.op, 0, !pr.typed);
				if (pr.typed)
					c_elems_due.push_back(pr.elem);
			end
		end

		// Random part: segments of sixteen picks plus operand fills, each with its
		// own dimensions and sender idling. The full size and the over-range
		// size get a segment each; the rest are mostly small.
		n_cmds_done = 0;
		for (seg = 0; seg < 6 || n_cmds_done < 200; seg++) begin
			pct = idle_pct[seg % 4];
			drain();
			case (seg)
				2:       set_dims(4'(MAX_DIM), 4'(MAX_DIM), 4'(MAX_DIM));
				4:       set_dims(4'd15, 4'd15, 4'd15);
				default: set_dims(pick_dim(), pick_dim(), pick_dim());
			endcase
			for (int k = 0; k < 16; k++) begin
				pick = $urandom_range(0, 99);
				if (k == 15 || (pick >= 80 && pick < 92)) begin
					fill_operands(pct);
					issue(mk_cmd(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
						$urandom()), pick_gap(pct), 1'b1);
				end else if (pick < 40) begin
					issue(mk_cmd(OP_WRITE_A, $urandom_range(0, 7), $urandom_range(0, 7),
						pick_value()), pick_gap(pct), 1'b1);
				end else if (pick < 80) begin
					issue(mk_cmd(OP_WRITE_B, $urandom_range(0, 7), $urandom_range(0, 7),
						pick_value()), pick_gap(pct), 1'b1);
				end else begin
					issue(mk_cmd(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
						$urandom()), pick_gap(pct), 1'b1);
				end
			end
		end

		// Wait out everything due, then watch a little longer for strays.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
